// ===== design/sacts_pkg.sv =====
// ----------------------------------------------------------------------------
// sacts_pkg: shared types and constants of the cache tag store
// Payload structs, configuration register indexes, reset values and the
// command/status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sacts_pkg;

    localparam int DEF_MAX_SETS  = 1024;
    localparam int DEF_MAX_WAYS  = 8;
    localparam int DEF_ADDR_BITS = 32;

    localparam int PORT_ADDR_W = 32;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int WAY_OUT_W   = 3;

    localparam logic [3:0] RST_OFFSET_BITS = 4'd5;
    localparam logic [3:0] RST_INDEX_BITS  = 4'd10;
    localparam logic [3:0] RST_WAYS_IN_USE = 4'd1;
    localparam logic       RST_REPLACE_LRU = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1,
        CFG_WAYS_IN_USE = 2'd2,
        CFG_REPLACE_LRU = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                   req_type;
        logic [PORT_ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic                 writeback_needed;
        logic [WAY_OUT_W-1:0] way_used;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } sts_t;

endpackage

// ===== design/sacts_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacts_ctrl: sequencing of the cache tag store
// Runs the clearing pass after reset, then alternates between waiting for
// an access and the lookup/update cycle of the accepted access.
// ----------------------------------------------------------------------------
module sacts_ctrl
    import sacts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= (state_reg == ST_LOOKUP);
        end
    end

    assign cmd.capture = (state_reg == ST_IDLE) && start;
    assign cmd.commit  = (state_reg == ST_LOOKUP);
    assign cmd.clear   = (state_reg == ST_CLEAR);
    assign busy        = busy_reg;
    assign done        = done_reg;

endmodule

// ===== design/sacts_dp.sv =====
// ----------------------------------------------------------------------------
// sacts_dp: datapath of the cache tag store
// Holds the configuration, splits the address, keeps one memory row per
// set and computes hit, victim, ages and the updated row.
// ----------------------------------------------------------------------------
module sacts_dp
    import sacts_pkg::*;
#(
    parameter int MAX_SETS  = DEF_MAX_SETS,
    parameter int MAX_WAYS  = DEF_MAX_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  req_t                  req,
    output rsp_t                  rsp,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    // Sets actually addressable: floor(log2(MAX_SETS)) index bits.
    localparam int SET_BITS = $clog2(MAX_SETS + 1) - 1;
    localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int DEPTH    = 2 ** SET_BITS;
    localparam int AW       = (ADDR_BITS < PORT_ADDR_W) ? ADDR_BITS : PORT_ADDR_W;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W    = WAY_W;
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int SH_W     = 6;

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

    // Configuration registers.
    logic [3:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [3:0] ways_in_use_reg;
    logic       replace_lru_reg;

    // Set memories, one row per set.
    logic [MAX_WAYS-1:0]             vld_mem [DEPTH];
    logic [MAX_WAYS-1:0]             drt_mem [DEPTH];
    logic [MAX_WAYS-1:0][AW-1:0]     tag_mem [DEPTH];
    logic [MAX_WAYS-1:0][AGE_W-1:0]  age_mem [DEPTH];
    logic [WAY_W-1:0]                ptr_mem [DEPTH];

    logic [MAX_WAYS-1:0]             vld_rd_reg;
    logic [MAX_WAYS-1:0]             drt_rd_reg;
    logic [MAX_WAYS-1:0][AW-1:0]     tag_rd_reg;
    logic [MAX_WAYS-1:0][AGE_W-1:0]  age_rd_reg;
    logic [WAY_W-1:0]                ptr_rd_reg;

    logic [IDX_W-1:0] set_reg;
    logic [AW-1:0]    tag_reg;
    logic             store_reg;
    logic [IDX_W-1:0] clr_idx_reg;
    rsp_t             rsp_reg;

    // Address split.
    logic [AW-1:0]    addr_m;
    logic [SH_W-1:0]  ib_c;
    logic [SH_W-1:0]  tag_sh;
    logic [IDX_W-1:0] idx_mask;
    logic [IDX_W-1:0] set_c;
    logic [AW-1:0]    tag_c;

    // Lookup and update.
    logic [CNT_W-1:0]               ways_c;
    logic [MAX_WAYS-1:0]            en;
    logic [MAX_WAYS-1:0]            match;
    logic [MAX_WAYS-1:0]            inv;
    logic                           hit;
    logic [WAY_W-1:0]               hit_way;
    logic [WAY_W-1:0]               inv_way;
    logic [WAY_W-1:0]               old_way;
    logic [AGE_W-1:0]               old_age;
    logic [WAY_W-1:0]               fifo_way;
    logic [WAY_W-1:0]               victim;
    logic                           was_valid;
    logic                           wb;
    logic [AGE_W-1:0]               mine;
    logic [MAX_WAYS-1:0]            vld_next;
    logic [MAX_WAYS-1:0]            drt_next;
    logic [MAX_WAYS-1:0][AW-1:0]    tag_next;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age_next;
    logic [WAY_W-1:0]               ptr_next;
    rsp_t                           rsp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= RST_OFFSET_BITS;
            index_bits_reg  <= RST_INDEX_BITS;
            ways_in_use_reg <= RST_WAYS_IN_USE;
            replace_lru_reg <= RST_REPLACE_LRU;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[3:0];
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[3:0];
                CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[3:0];
                CFG_REPLACE_LRU: replace_lru_reg <= cfg_data[0];
                default:         replace_lru_reg <= replace_lru_reg;
            endcase
        end
    end

    always_comb
    begin
        addr_m = req.address[AW-1:0];
        if (SH_W'(index_bits_reg) > SH_W'(SET_BITS))
        begin
            ib_c = SH_W'(SET_BITS);
        end
        else
        begin
            ib_c = SH_W'(index_bits_reg);
        end
        tag_sh   = SH_W'(offset_bits_reg) + ib_c;
        idx_mask = ~({IDX_W{1'b1}} << ib_c);
        set_c    = IDX_W'(addr_m >> offset_bits_reg) & idx_mask;
        tag_c    = addr_m >> tag_sh;
    end

    always_comb
    begin
        if (ways_in_use_reg == 4'd0)
        begin
            ways_c = CNT_W'(1);
        end
        else if (32'(ways_in_use_reg) > MAX_WAYS)
        begin
            ways_c = CNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_c = CNT_W'(ways_in_use_reg);
        end
    end

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            en[w]    = (CNT_W'(w) < ways_c);
            match[w] = en[w] && vld_rd_reg[w] && (tag_rd_reg[w] == tag_reg);
            inv[w]   = en[w] && !vld_rd_reg[w];
        end
        hit     = |match;
        hit_way = '0;
        inv_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (inv[w])
            begin
                inv_way = WAY_W'(w);
            end
        end
        // Oldest way; ties go to the lowest way.
        old_way = '0;
        old_age = age_rd_reg[0];
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (en[w] && (age_rd_reg[w] > old_age))
            begin
                old_age = age_rd_reg[w];
                old_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        // A stale pointer at or beyond the way count falls back to way zero.
        if (CNT_W'(ptr_rd_reg) >= ways_c)
        begin
            fifo_way = '0;
        end
        else
        begin
            fifo_way = ptr_rd_reg;
        end
        if (CNT_W'(fifo_way) + CNT_W'(1) >= ways_c)
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = WAY_W'(CNT_W'(fifo_way) + CNT_W'(1));
        end

        if (hit)
        begin
            victim = hit_way;
        end
        else if (replace_lru_reg)
        begin
            victim = (|inv) ? inv_way : old_way;
        end
        else
        begin
            victim = fifo_way;
        end

        was_valid = vld_rd_reg[victim];
        wb        = !hit && vld_rd_reg[victim] && drt_rd_reg[victim];
        mine      = age_rd_reg[victim];

        // Ways younger than the touched one age by one; filling a way that was
        // invalid ages every other valid way.
        for (int v = 0; v < MAX_WAYS; v++)
        begin
            age_next[v] = age_rd_reg[v];
            if ((WAY_W'(v) != victim) && en[v] && vld_rd_reg[v]
                && (!was_valid || (age_rd_reg[v] < mine))
                && (age_rd_reg[v] < AGE_MAX))
            begin
                age_next[v] = age_rd_reg[v] + AGE_W'(1);
            end
        end
        age_next[victim] = '0;

        vld_next = vld_rd_reg;
        drt_next = drt_rd_reg;
        tag_next = tag_rd_reg;
        if (hit)
        begin
            if (store_reg)
            begin
                drt_next[victim] = 1'b1;
            end
        end
        else
        begin
            vld_next[victim] = 1'b1;
            drt_next[victim] = store_reg;
            tag_next[victim] = tag_reg;
        end

        rsp_next.hit              = hit;
        rsp_next.writeback_needed = wb;
        rsp_next.way_used         = WAY_OUT_W'(victim);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            vld_mem[clr_idx_reg] <= '0;
            drt_mem[clr_idx_reg] <= '0;
            tag_mem[clr_idx_reg] <= '0;
            age_mem[clr_idx_reg] <= '0;
            ptr_mem[clr_idx_reg] <= '0;
        end
        else if (cmd.commit)
        begin
            vld_mem[set_reg] <= vld_next;
            drt_mem[set_reg] <= drt_next;
            tag_mem[set_reg] <= tag_next;
            age_mem[set_reg] <= age_next;
            if (!hit && !replace_lru_reg)
            begin
                ptr_mem[set_reg] <= ptr_next;
            end
        end
        if (cmd.capture)
        begin
            vld_rd_reg <= vld_mem[set_c];
            drt_rd_reg <= drt_mem[set_c];
            tag_rd_reg <= tag_mem[set_c];
            age_rd_reg <= age_mem[set_c];
            ptr_rd_reg <= ptr_mem[set_c];
            set_reg    <= set_c;
            tag_reg    <= tag_c;
            store_reg  <= req.req_type;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_idx_reg <= clr_idx_reg + IDX_W'(1);
        end
    end

    assign sts.clear_last = (clr_idx_reg == IDX_W'(DEPTH - 1));
    assign rsp            = rsp_reg;

endmodule

// ===== design/set_assoc_cache_tag_store.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store: tag store of a write-back set-associative cache
// Looks up each load or store, fills a victim way on a miss (per-set FIFO
// or LRU with invalid ways first) and reports hit, write-back and way.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low. Each access is a
// synchronous read of the set row, then the lookup and the write-back of the
// updated row, so busy is high during the lookup of each accepted access.
// The result appears with done for exactly one cycle, the cycle after the
// lookup, and must be taken then. After reset the block sweeps the set
// memory once, one set per cycle over all 2**floor(log2(MAX_SETS)) sets,
// 1024 by default, with busy high; configuration writes are taken at
// any time and should be made only while no access is in flight.
module set_assoc_cache_tag_store
    import sacts_pkg::*;
#(
    parameter int MAX_SETS  = DEF_MAX_SETS,
    parameter int MAX_WAYS  = DEF_MAX_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  done,
    output rsp_t                  rsp,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    sacts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    sacts_dp #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== design/sacts_checker.sv =====
// ----------------------------------------------------------------------------
// sacts_checker: port-level checks of the cache tag store
// Timing of accepted accesses against busy and done, and result coherence.
// ----------------------------------------------------------------------------
module sacts_checker
    import sacts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // Every accepted beat is followed by its result on done.
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted access did not produce a result in time");

    // The block holds off new beats while an access is in flight.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted access");

    // A result only follows a busy cycle and frees the input side.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe outside an access");

    // Results never arrive back to back.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    // A hit never evicts a line.
    a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.hit) |-> !rsp.writeback_needed)
        else $error("write-back reported on a hit");

endmodule

bind set_assoc_cache_tag_store sacts_checker u_sacts_checker (.*);

// ===== tb/tb_set_assoc_cache_tag_store.sv =====
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_store: self-checking bench for the cache tag store
// A short scripted run checks the reset configuration, address extremes,
// write-back on dirty eviction and the register corner cases. Random phases
// under several configurations follow. Every beat is predicted by a shadow
// tag store or set by the script, and compared per field in arrival order.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_store;
    import sacts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_LOG2   = $clog2(DEF_MAX_SETS);
    localparam int N_PHASES   = 12;
    localparam int PHASE_LEN  = 145;
    localparam int MAX_CYCLES = 300000;

    typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        req_t       access;
        logic       known;
        rsp_t       result;
        cfg_idx_t   reg_sel;
        logic [3:0] reg_val;
    } script_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    req_t                  req       = '0;
    logic                  done;
    rsp_t                  rsp;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the tag store and its configuration.
    logic        line_ok    [DEF_MAX_SETS][DEF_MAX_WAYS];
    logic        line_mod   [DEF_MAX_SETS][DEF_MAX_WAYS];
    logic [31:0] line_tagv  [DEF_MAX_SETS][DEF_MAX_WAYS];
    logic [2:0]  line_rank  [DEF_MAX_SETS][DEF_MAX_WAYS];
    logic [2:0]  fifo_ptr   [DEF_MAX_SETS];
    logic [3:0]  cur_offset = RST_OFFSET_BITS;
    logic [3:0]  cur_index  = RST_INDEX_BITS;
    logic [3:0]  cur_ways   = RST_WAYS_IN_USE;
    logic        cur_lru    = RST_REPLACE_LRU;

    rsp_t        pending_q [$];
    script_row_t script_q [$];
    int          mismatches = 0;
    int          cycles     = 0;

    // Address pool of the current random phase.
    logic [31:0] hot_sets [3];
    logic [31:0] tag_pool [10];
    int          pool_size;

    set_assoc_cache_tag_store uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned eff_index_bits();
        return (cur_index > SET_LOG2) ? SET_LOG2 : cur_index;
    endfunction

    function automatic int unsigned eff_ways();
        if (cur_ways == 0)
            return 1;
        return (cur_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : cur_ways;
    endfunction

    // Ages count how many valid ways were used more recently. A way that was
    // invalid pushes every valid way back by one; a reused way only those
    // that were younger than itself.
    function automatic void refresh_ages(int unsigned set_no, int unsigned nways,
                                         int unsigned w, logic was_valid);
        logic [2:0] mine;
        mine = line_rank[set_no][w];
        for (int unsigned v = 0; v < nways; v++)
        begin
            if (v == w || !line_ok[set_no][v])
                continue;
            if (!was_valid || line_rank[set_no][v] < mine)
            begin
                if (line_rank[set_no][v] < DEF_MAX_WAYS - 1)
                    line_rank[set_no][v] = line_rank[set_no][v] + 3'd1;
            end
        end
        line_rank[set_no][w] = '0;
    endfunction

    function automatic rsp_t lookup_and_fill(req_t r);
        int unsigned ib, nways, set_no, victim, best;
        logic [31:0] tag;
        logic        hit, found, was_valid;
        rsp_t        res;
        ib     = eff_index_bits();
        nways  = eff_ways();
        set_no = (r.address >> cur_offset) & ((32'd1 << ib) - 1);
        tag    = r.address >> (cur_offset + ib);
        hit    = 1'b0;
        victim = 0;
        res    = '0;
        for (int unsigned w = 0; w < nways; w++)
        begin
            if (!hit && line_ok[set_no][w] && line_tagv[set_no][w] == tag)
            begin
                hit    = 1'b1;
                victim = w;
            end
        end
        if (hit)
        begin
            if (r.req_type)
                line_mod[set_no][victim] = 1'b1;
            refresh_ages(set_no, nways, victim, 1'b1);
        end
        else
        begin
            if (cur_lru)
            begin
                found = 1'b0;
                for (int unsigned w = 0; w < nways; w++)
                begin
                    if (!found && !line_ok[set_no][w])
                    begin
                        victim = w;
                        found  = 1'b1;
                    end
                end
                if (!found)
                begin
                    best = 0;
                    for (int unsigned w = 0; w < nways; w++)
                    begin
                        if (w == 0 || 32'(line_rank[set_no][w]) > best)
                        begin
                            best   = 32'(line_rank[set_no][w]);
                            victim = w;
                        end
                    end
                end
            end
            else
            begin
                victim = 32'(fifo_ptr[set_no]);
                if (victim >= nways)
                    victim = 0;
                fifo_ptr[set_no] = (victim + 1 >= nways) ? 3'd0 : 3'(victim + 1);
            end
            was_valid = line_ok[set_no][victim];
            res.writeback_needed = was_valid && line_mod[set_no][victim];
            refresh_ages(set_no, nways, victim, was_valid);
            line_ok[set_no][victim]   = 1'b1;
            line_tagv[set_no][victim] = tag;
            line_mod[set_no][victim]  = r.req_type;
        end
        res.hit      = hit;
        res.way_used = 3'(victim);
        return res;
    endfunction

    function automatic void add_access(logic st, logic [31:0] addr, logic known,
                                       logic h, logic wb, logic [2:0] way);
        script_row_t row;
        row.kind                    = ROW_ACCESS;
        row.access.req_type         = st;
        row.access.address          = addr;
        row.known                   = known;
        row.result.hit              = h;
        row.result.writeback_needed = wb;
        row.result.way_used         = way;
        row.reg_sel                 = CFG_OFFSET_BITS;
        row.reg_val                 = '0;
        script_q.push_back(row);
    endfunction

    function automatic void add_write(cfg_idx_t sel, logic [3:0] val);
        script_row_t row;
        row.kind    = ROW_CONFIG;
        row.access  = '0;
        row.known   = 1'b0;
        row.result  = '0;
        row.reg_sel = sel;
        row.reg_val = val;
        script_q.push_back(row);
    endfunction

    function automatic req_t next_random_access();
        req_t        r;
        int unsigned shift;
        logic [31:0] low;
        r.req_type = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15)
        begin
            case ($urandom_range(0, 5))
                0:       r.address = '0;
                1:       r.address = '1;
                default: r.address = $urandom;
            endcase
        end
        else
        begin
            shift = cur_offset + eff_index_bits();
            low   = $urandom & ((32'd1 << cur_offset) - 1);
            r.address = (tag_pool[$urandom_range(0, pool_size - 1)] << shift)
                      | (hot_sets[$urandom_range(0, 2)] << cur_offset) | low;
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, int got, int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(cfg_idx_t sel, logic [3:0] val);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        case (sel)
            CFG_OFFSET_BITS: cur_offset = val;
            CFG_INDEX_BITS:  cur_index  = val;
            CFG_WAYS_IN_USE: cur_ways   = val;
            CFG_REPLACE_LRU: cur_lru    = val[0];
            default:         ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Holds start low until every predicted beat has come back.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic idle_gap(int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic issue_access(req_t r, logic known, rsp_t typed);
        rsp_t want;
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = lookup_and_fill(r);
        pending_q.push_back(known ? typed : want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
                note_mismatch("unexpected result beat", 1, 0);
            else
            begin
                if (rsp.hit !== pending_q[0].hit)
                    note_mismatch("hit", rsp.hit, pending_q[0].hit);
                if (rsp.writeback_needed !== pending_q[0].writeback_needed)
                    note_mismatch("writeback_needed", rsp.writeback_needed,
                                  pending_q[0].writeback_needed);
                if (rsp.way_used !== pending_q[0].way_used)
                    note_mismatch("way_used", rsp.way_used, pending_q[0].way_used);
                void'(pending_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= MAX_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int idle_pct;
        for (int s = 0; s < DEF_MAX_SETS; s++)
        begin
            fifo_ptr[s] = '0;
            for (int w = 0; w < DEF_MAX_WAYS; w++)
            begin
                line_ok[s][w]   = 1'b0;
                line_mod[s][w]  = 1'b0;
                line_tagv[s][w] = '0;
                line_rank[s][w] = '0;
            end
        end

        // Reset configuration: 5 offset bits, 10 index bits, direct mapped.
        add_access(1'b0, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 3'd0);
        add_access(1'b1, 32'h0000_001F, 1'b1, 1'b1, 1'b0, 3'd0);
        add_access(1'b0, 32'h0000_8000, 1'b1, 1'b0, 1'b1, 3'd0);
        add_access(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 3'd0);
        add_access(1'b0, 32'hFFFF_FFE0, 1'b1, 1'b1, 1'b0, 3'd0);
        add_access(1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, 3'd0);
        add_access(1'b0, 32'h0000_8000, 1'b1, 1'b1, 1'b0, 3'd0);
        // Four-way LRU: invalid ways fill first, then the oldest goes.
        add_write(CFG_WAYS_IN_USE, 4'd4);
        add_write(CFG_REPLACE_LRU, 4'd1);
        add_access(1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 3'd0);
        add_access(1'b0, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 3'd0);
        add_access(1'b0, 32'h0001_8000, 1'b0, 1'b0, 1'b0, 3'd0);
        add_access(1'b0, 32'h0000_8000, 1'b0, 1'b0, 1'b0, 3'd0);
        add_access(1'b0, 32'h0002_0000, 1'b0, 1'b0, 1'b0, 3'd0);
        // Zero ways acts as one, index bits clamp, no offset.
        add_write(CFG_WAYS_IN_USE, 4'd0);
        add_write(CFG_INDEX_BITS, 4'd15);
        add_write(CFG_OFFSET_BITS, 4'd0);
        add_write(CFG_REPLACE_LRU, 4'd0);
        add_access(1'b1, 32'h0000_03FF, 1'b0, 1'b0, 1'b0, 3'd0);
        add_access(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 3'd0);
        add_access(1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 3'd0);
        // Way count saturates, a single set, FIFO wraps past the last way.
        add_write(CFG_WAYS_IN_USE, 4'd15);
        add_write(CFG_OFFSET_BITS, 4'd12);
        add_write(CFG_INDEX_BITS, 4'd0);
        for (int k = 0; k < 9; k++)
            add_access(1'b1, 32'(k) << 12, 1'b0, 1'b0, 1'b0, 3'd0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script_q[i])
        begin
            if (script_q[i].kind == ROW_CONFIG)
            begin
                drain();
                write_reg(script_q[i].reg_sel, script_q[i].reg_val);
            end
            else
            begin
                idle_gap(27);
                issue_access(script_q[i].access, script_q[i].known, script_q[i].result);
            end
        end

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    write_reg(CFG_OFFSET_BITS, 4'd0);
                    write_reg(CFG_INDEX_BITS, 4'd0);
                    write_reg(CFG_WAYS_IN_USE, 4'd1);
                    write_reg(CFG_REPLACE_LRU, 4'd0);
                end
                1:
                begin
                    write_reg(CFG_OFFSET_BITS, 4'd15);
                    write_reg(CFG_INDEX_BITS, 4'd15);
                    write_reg(CFG_WAYS_IN_USE, 4'd15);
                    write_reg(CFG_REPLACE_LRU, 4'd1);
                end
                2:
                begin
                    write_reg(CFG_OFFSET_BITS, 4'd12);
                    write_reg(CFG_INDEX_BITS, 4'd10);
                    write_reg(CFG_WAYS_IN_USE, 4'd8);
                    write_reg(CFG_REPLACE_LRU, 4'd1);
                end
                default:
                begin
                    write_reg(CFG_OFFSET_BITS, 4'($urandom_range(0, 15)));
                    write_reg(CFG_INDEX_BITS, 4'($urandom_range(0, 15)));
                    write_reg(CFG_WAYS_IN_USE, 4'($urandom_range(0, 15)));
                    write_reg(CFG_REPLACE_LRU, 4'($urandom_range(0, 15)));
                end
            endcase

            // A few hot sets and a small tag pool give hits and evictions.
            for (int k = 0; k < 3; k++)
                hot_sets[k] = $urandom_range(0, (1 << eff_index_bits()) - 1);
            pool_size = eff_ways() + 2;
            for (int k = 0; k < pool_size; k++)
                tag_pool[k] = $urandom;

            if (phase < 4)
                idle_pct = 27;
            else if (phase < 8)
                idle_pct = 55;
            else
                idle_pct = 0;

            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (phase == 5 && n == 70)
                    drain();
                idle_gap(idle_pct);
                issue_access(next_random_access(), 1'b0, '0);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/sacts_pkg.sv
design/sacts_ctrl.sv
design/sacts_dp.sv
design/set_assoc_cache_tag_store.sv
design/sacts_checker.sv
tb/tb_set_assoc_cache_tag_store.sv
